// ===== rtl/bcq_pkg.sv =====
package bcq_pkg;

  // Queued button bits are word bits 4-15: directions in [3:0], face/shoulder in [11:4].
  localparam int QW = 12;
  localparam int DIR_W = 4;
  localparam int WORD_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W = 10;
  localparam int SPAN_W = 20;
  localparam int MS_TO_US = 1000;

  typedef enum logic {
    OP_PUSH    = 1'b0,
    OP_OVERLAY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_NORMAL     = 2'd0,
    KIND_DIR_EMPTY  = 2'd1,
    KIND_FACE_EMPTY = 2'd2,
    KIND_BOTH_EMPTY = 2'd3
  } kind_e;

  typedef enum logic {
    REG_CHORD_WINDOW = 1'b0,
    REG_HOLD         = 1'b1
  } reg_e;

  // Per-device bookkeeping; the newest slot's pressed set equals last_pressed.
  typedef struct packed {
    logic [QW-1:0]     last_pressed;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] hold_start;
    logic              hold_run;
    logic [QW-1:0]     newest_newly;
    kind_e             newest_kind;
  } dev_state_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] buttons_out;
    logic              from_queue;
  } result_t;

endpackage

// ===== rtl/button_chord_event_queue.sv =====
// Button chord event queue: one ring of gesture slots per controller port.
// Only overlays make result items, via the compute stage and result registers.
// Throughput: one item per cycle while no overlay result waits on a held result;
// the single compute stage before the result register sets it; RAM read at accept.
// Reset (async, active low) clears pointers, timestamps, hold state and the
// config registers; the slot RAM is not cleared and is only used once written.
module button_chord_event_queue #(
  parameter int DEVICES     = 4,
  parameter int QUEUE_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [1:0]  device_i,
  input  logic [15:0] buttons_i,
  input  logic [31:0] now_us_i,
  // Result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] buttons_out_o,
  output logic        from_queue_o
);

  localparam int DevW     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int PtrW     = $clog2(QUEUE_SLOTS);
  localparam int AddrW    = DevW + PtrW;
  localparam int RamDepth = 1 << AddrW;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_SLOTS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers: keep the ms values for readback and the scaled
  // microsecond spans for the compare logic.
  // ---------------------------------------------------------------------------
  bcq_pkg::reg_e                   reg_sel;
  logic                            cfg_wr;
  logic [bcq_pkg::CFG_W-1:0]       chord_ms_q, hold_ms_q;
  logic [bcq_pkg::SPAN_W-1:0]      chord_us_q, hold_us_q, span_us_d;

  assign pready    = 1'b1;
  assign reg_sel   = bcq_pkg::reg_e'(paddr[2]);
  assign cfg_wr    = psel && penable && pwrite;
  assign span_us_d = bcq_pkg::SPAN_W'(pwdata[bcq_pkg::CFG_W-1:0]) *
                     bcq_pkg::SPAN_W'(bcq_pkg::MS_TO_US);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_ms_q <= '0;
      hold_ms_q  <= '0;
      chord_us_q <= '0;
      hold_us_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        bcq_pkg::REG_CHORD_WINDOW: begin
          chord_ms_q <= pwdata[bcq_pkg::CFG_W-1:0];
          chord_us_q <= span_us_d;
        end
        bcq_pkg::REG_HOLD: begin
          hold_ms_q <= pwdata[bcq_pkg::CFG_W-1:0];
          hold_us_q <= span_us_d;
        end
        default: begin
          hold_ms_q <= hold_ms_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bcq_pkg::REG_CHORD_WINDOW: prdata = 32'(chord_ms_q);
      bcq_pkg::REG_HOLD:         prdata = 32'(hold_ms_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-device state, read once at accept and written back by the compute stage.
  // ---------------------------------------------------------------------------
  bcq_pkg::dev_state_t st_q   [DEVICES];
  logic [PtrW-1:0]     head_q [DEVICES];
  logic [PtrW-1:0]     tail_q [DEVICES];

  // Compute stage registers
  logic                        b_valid_q;
  bcq_pkg::op_e                b_op_q;
  logic [1:0]                  b_dev_q;
  logic                        b_dev_ok_q;
  logic [15:0]                 b_buttons_q;
  logic [31:0]                 b_now_q;
  bcq_pkg::dev_state_t         b_st_q;
  logic [PtrW-1:0]             b_head_q, b_tail_q;
  logic                        byp0_q, byp1_q;
  logic [bcq_pkg::QW-1:0]      byp_data_q;

  // Result register
  logic                        res_valid_q;
  logic [15:0]                 buttons_out_q;
  logic                        from_queue_q;

  // Step outputs
  bcq_pkg::dev_state_t         step_st;
  logic [PtrW-1:0]             step_head, step_tail, step_wr_ptr;
  logic                        step_wr_en;
  logic [bcq_pkg::QW-1:0]      step_wr_data;
  bcq_pkg::result_t            step_res;

  logic                        in_fire, b_fire, in_dev_ok, fwd, ram_we;
  logic [DevW-1:0]             in_idx, b_idx;
  bcq_pkg::dev_state_t         fetch_st;
  logic [PtrW-1:0]             fetch_head, fetch_tail, fetch_tail_inc;
  logic [AddrW-1:0]            rd_addr0, rd_addr1, wr_addr;
  logic [bcq_pkg::QW-1:0]      ram_rd0, ram_rd1, tail_slot, next_slot;

  // Advance the compute stage unless an overlay result would overrun a
  // result item that is still waiting.
  assign b_fire     = b_valid_q &&
                      (b_op_q == bcq_pkg::OP_PUSH || !res_valid_q || out_ready_i);
  assign in_ready_o = !b_valid_q || b_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_dev_ok = (32'(device_i) < 32'(DEVICES));
  assign in_idx    = in_dev_ok ? DevW'(device_i) : '0;
  assign b_idx     = b_dev_ok_q ? DevW'(b_dev_q) : '0;

  // Forward the compute stage's fresh state when both items hit one device.
  assign fwd        = b_valid_q && b_dev_ok_q && (device_i == b_dev_q);
  assign fetch_st   = fwd ? step_st   : st_q[in_idx];
  assign fetch_head = fwd ? step_head : head_q[in_idx];
  assign fetch_tail = fwd ? step_tail : tail_q[in_idx];
  assign fetch_tail_inc = (fetch_tail == LastPtr) ? '0 : fetch_tail + 1'b1;

  // Read the oldest slot and the one behind it; an overlay may show either.
  assign rd_addr0 = {in_idx, fetch_tail};
  assign rd_addr1 = {in_idx, fetch_tail_inc};
  assign ram_we   = b_fire && b_dev_ok_q && step_wr_en;
  assign wr_addr  = {b_idx, step_wr_ptr};

  bcq_ram #(
    .WIDTH (bcq_pkg::QW),
    .DEPTH (RamDepth)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (wr_addr),
    .wdata_i  (step_wr_data),
    .re_i     (in_fire),
    .raddr0_i (rd_addr0),
    .raddr1_i (rd_addr1),
    .rdata0_o (ram_rd0),
    .rdata1_o (ram_rd1)
  );

  // Bypass the slot written on the same edge as the read.
  assign tail_slot = byp0_q ? byp_data_q : ram_rd0;
  assign next_slot = byp1_q ? byp_data_q : ram_rd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_fire) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_op_q      <= bcq_pkg::op_e'(op_i);
      b_dev_q     <= device_i;
      b_dev_ok_q  <= in_dev_ok;
      b_buttons_q <= buttons_i;
      b_now_q     <= now_us_i;
      b_st_q      <= fetch_st;
      b_head_q    <= fetch_head;
      b_tail_q    <= fetch_tail;
      byp0_q      <= ram_we && (wr_addr == rd_addr0);
      byp1_q      <= ram_we && (wr_addr == rd_addr1);
      byp_data_q  <= step_wr_data;
    end
  end

  bcq_step #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_step (
    .op_i        (b_op_q),
    .dev_ok_i    (b_dev_ok_q),
    .buttons_i   (b_buttons_q),
    .now_us_i    (b_now_q),
    .st_i        (b_st_q),
    .head_i      (b_head_q),
    .tail_i      (b_tail_q),
    .tail_slot_i (tail_slot),
    .next_slot_i (next_slot),
    .chord_us_i  (chord_us_q),
    .hold_us_i   (hold_us_q),
    .st_o        (step_st),
    .head_o      (step_head),
    .tail_o      (step_tail),
    .wr_en_o     (step_wr_en),
    .wr_ptr_o    (step_wr_ptr),
    .wr_data_o   (step_wr_data),
    .res_o       (step_res)
  );

  // Write back the device state as the item leaves the compute stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEVICES; i++) begin
        st_q[i]   <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else if (b_fire && b_dev_ok_q) begin
      st_q[b_idx]   <= step_st;
      head_q[b_idx] <= step_head;
      tail_q[b_idx] <= step_tail;
    end
  end

  // Result register: load on an overlay, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (b_fire && step_res.valid) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && step_res.valid) begin
      buttons_out_q <= step_res.buttons_out;
      from_queue_q  <= step_res.from_queue;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign buttons_out_o = buttons_out_q;
  assign from_queue_o  = from_queue_q;

endmodule

// ===== rtl/bcq_ram.sv =====
module bcq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// ===== rtl/bcq_step.sv =====
module bcq_step #(
  parameter int QUEUE_SLOTS = 8,
  localparam int PtrW = $clog2(QUEUE_SLOTS)
) (
  input  bcq_pkg::op_e                    op_i,
  input  logic                            dev_ok_i,
  input  logic [bcq_pkg::WORD_W-1:0]      buttons_i,
  input  logic [bcq_pkg::TIME_W-1:0]      now_us_i,
  input  bcq_pkg::dev_state_t             st_i,
  input  logic [PtrW-1:0]                 head_i,
  input  logic [PtrW-1:0]                 tail_i,
  input  logic [bcq_pkg::QW-1:0]          tail_slot_i,
  input  logic [bcq_pkg::QW-1:0]          next_slot_i,
  input  logic [bcq_pkg::SPAN_W-1:0]      chord_us_i,
  input  logic [bcq_pkg::SPAN_W-1:0]      hold_us_i,
  output bcq_pkg::dev_state_t             st_o,
  output logic [PtrW-1:0]                 head_o,
  output logic [PtrW-1:0]                 tail_o,
  output logic                            wr_en_o,
  output logic [PtrW-1:0]                 wr_ptr_o,
  output logic [bcq_pkg::QW-1:0]          wr_data_o,
  output bcq_pkg::result_t                res_o
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_SLOTS - 1);

  logic [bcq_pkg::QW-1:0]    ah, last, newly, rel, newly_r, app_newly;
  logic [bcq_pkg::DIR_W-1:0] dir, ndir_r, sdir, pdir;
  logic [7:0]                face, nface, sface, pface;
  logic                      dchg, frel, roll, empty, inwin, veto_rule, veto;
  bcq_pkg::kind_e            kind, sk;
  logic [PtrW-1:0]           head_inc, head_dec, tail_inc;
  logic [bcq_pkg::TIME_W-1:0] push_gap, hold_start, hold_gap;
  logic                      expired;

  assign head_inc = (head_i == LastPtr) ? '0 : head_i + 1'b1;
  assign head_dec = (head_i == '0) ? LastPtr : head_i - 1'b1;
  assign tail_inc = (tail_i == LastPtr) ? '0 : tail_i + 1'b1;
  assign empty    = (head_i == tail_i);

  // Held set is the active-high view of bits 4-15.
  assign ah    = ~buttons_i[bcq_pkg::WORD_W-1:bcq_pkg::DIR_W];
  assign last  = st_i.last_pressed;
  assign dir   = ah[3:0];
  assign face  = ah[11:4];
  assign newly = ah & ~last;
  assign rel   = last & ~ah;
  assign nface = newly[11:4];
  assign dchg  = (dir != last[3:0]);
  assign frel  = (|rel[11:4]) && !(|nface);
  // Roll-over: only directions let go while another direction stays down.
  assign roll  = (|rel[3:0]) && (|dir) && !(|rel[11:4]) && !(|nface);

  assign newly_r   = roll ? {8'b0, dir} : newly;
  assign ndir_r    = newly_r[3:0];
  assign app_newly = ((|rel[3:0]) && (|dir)) ? {8'b0, dir} : newly_r;

  always_comb begin
    priority if ((|dir) || (|face)) begin
      kind = bcq_pkg::KIND_NORMAL;
    end else if (dchg && frel) begin
      kind = bcq_pkg::KIND_BOTH_EMPTY;
    end else if (dchg) begin
      kind = bcq_pkg::KIND_DIR_EMPTY;
    end else if (frel) begin
      kind = bcq_pkg::KIND_FACE_EMPTY;
    end else begin
      kind = bcq_pkg::KIND_NORMAL;
    end
  end

  // Newest slot contents.
  assign sdir  = last[3:0];
  assign sface = last[11:4];
  assign pdir  = st_i.newest_newly[3:0];
  assign pface = st_i.newest_newly[11:4];
  assign sk    = st_i.newest_kind;

  assign push_gap = now_us_i - st_i.last_time;
  assign inwin    = (chord_us_i != '0) && !empty &&
                    (push_gap <= bcq_pkg::TIME_W'(chord_us_i));

  always_comb begin
    priority if ((|rel) && !roll) begin
      veto_rule = 1'b1;
    end else if (|newly_r) begin
      veto_rule = ((|nface) && (|pdir) && !(|pface)) ||
                  ((|ndir_r) && (|pdir) && !(|pface)) ||
                  ((|nface) && !(|sface) && (|sdir)) ||
                  ((|nface) && !(|sface) && !(|sdir) &&
                   (sk == bcq_pkg::KIND_FACE_EMPTY || sk == bcq_pkg::KIND_BOTH_EMPTY)) ||
                  ((|ndir_r) && !(|sdir) && !(|sface) &&
                   (sk == bcq_pkg::KIND_DIR_EMPTY || sk == bcq_pkg::KIND_BOTH_EMPTY));
    end else begin
      veto_rule = 1'b0;
    end
  end

  assign veto = !inwin || veto_rule;

  // Hold timer for the overlay.
  assign hold_start = st_i.hold_run ? st_i.hold_start : now_us_i;
  assign hold_gap   = now_us_i - hold_start;
  assign expired    = (hold_gap >= bcq_pkg::TIME_W'(hold_us_i));

  always_comb begin
    st_o              = st_i;
    head_o            = head_i;
    tail_o            = tail_i;
    wr_en_o           = 1'b0;
    wr_ptr_o          = head_i;
    wr_data_o         = ah;
    res_o.valid       = (op_i == bcq_pkg::OP_OVERLAY);
    res_o.buttons_out = buttons_i;
    res_o.from_queue  = 1'b0;
    if (dev_ok_i) begin
      unique case (op_i)
        bcq_pkg::OP_PUSH: begin
          if (ah != last) begin
            wr_en_o = 1'b1;
            if (!veto) begin
              // Merge into the newest slot.
              wr_ptr_o          = head_dec;
              st_o.newest_newly = newly_r;
            end else begin
              // Append; drop the oldest slot when the ring is full.
              head_o            = head_inc;
              st_o.newest_newly = app_newly;
              if (head_inc == tail_i) begin
                tail_o        = tail_inc;
                st_o.hold_run = 1'b0;
              end
            end
            st_o.newest_kind  = kind;
            st_o.last_pressed = ah;
            st_o.last_time    = now_us_i;
          end
        end
        bcq_pkg::OP_OVERLAY: begin
          if (!empty) begin
            res_o.from_queue  = 1'b1;
            res_o.buttons_out = {~tail_slot_i, buttons_i[bcq_pkg::DIR_W-1:0]};
            if (hold_us_i == '0) begin
              tail_o = tail_inc;
            end else begin
              st_o.hold_run   = 1'b1;
              st_o.hold_start = hold_start;
              if (expired) begin
                tail_o = tail_inc;
                if (head_i == tail_inc) begin
                  st_o.hold_run     = 1'b0;
                  res_o.from_queue  = 1'b0;
                  res_o.buttons_out = buttons_i;
                end else begin
                  st_o.hold_start   = now_us_i;
                  res_o.buttons_out = {~next_slot_i, buttons_i[bcq_pkg::DIR_W-1:0]};
                end
              end
            end
          end
        end
        default: begin
          st_o = st_i;
        end
      endcase
    end
  end

endmodule
